FILE: rtl/core/sbrb_pkg.sv
package sbrb_pkg;

	// Fixed sizes
	localparam int TIMER_BITS   = 16;
	localparam int DUR_W        = 12;
	localparam int PRESS_W      = 8;
	localparam int CNT_W        = 4;
	localparam int DELTA_W      = 14;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;
	localparam int SUM_W        = ((TIMER_BITS > DELTA_W) ? TIMER_BITS : DELTA_W) + 1;

	// Blink counts and time steps
	localparam int MAX_BLINKS   = 15;
	localparam int TICK_MS      = 100;
	localparam int FAST_STEP_MS = 5000;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Register reset values
	localparam logic [DUR_W-1:0]   RST_PAUSE_START = DUR_W'(500);
	localparam logic [DUR_W-1:0]   RST_FIRST_ON    = DUR_W'(250);
	localparam logic [DUR_W-1:0]   RST_FIRST_OFF   = DUR_W'(250);
	localparam logic [DUR_W-1:0]   RST_PAUSE_MID   = DUR_W'(250);
	localparam logic [DUR_W-1:0]   RST_SECOND_ON   = DUR_W'(350);
	localparam logic [DUR_W-1:0]   RST_SECOND_OFF  = DUR_W'(150);
	localparam logic [DUR_W-1:0]   RST_PAUSE_END   = DUR_W'(650);
	localparam logic [PRESS_W-1:0] RST_LONG_PRESS  = PRESS_W'(30);

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [2:0] {
		PH_INIT,
		PH_PAUSE_START,
		PH_FIRST_ON,
		PH_FIRST_OFF,
		PH_PAUSE_MID,
		PH_SECOND_ON,
		PH_SECOND_OFF,
		PH_PAUSE_END
	} phase_t;

	typedef enum logic [2:0] {
		REG_PAUSE_START,
		REG_FIRST_ON,
		REG_FIRST_OFF,
		REG_PAUSE_MID,
		REG_SECOND_ON,
		REG_SECOND_OFF,
		REG_PAUSE_END,
		REG_LONG_PRESS
	} reg_idx_t;

	typedef struct packed {
		logic [DUR_W-1:0]   pause_start_ms;
		logic [DUR_W-1:0]   first_on_ms;
		logic [DUR_W-1:0]   first_off_ms;
		logic [DUR_W-1:0]   pause_mid_ms;
		logic [DUR_W-1:0]   second_on_ms;
		logic [DUR_W-1:0]   second_off_ms;
		logic [DUR_W-1:0]   pause_end_ms;
		logic [PRESS_W-1:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		timer_t           timer;
		logic [CNT_W-1:0] done;
		logic             led_first;
		logic             led_second;
	} blink_state_t;

	typedef struct packed {
		logic led_first;
		logic led_second;
		logic erase_request;
		logic restart_request;
	} result_t;

	// Clamp a blink count to the supported maximum
	function automatic logic [CNT_W-1:0] clamp_blinks(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (int'(n) > MAX_BLINKS) begin
			r = CNT_W'(MAX_BLINKS);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/sbrb_apb_regs.sv
module sbrb_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbrb_pkg::ADDR_W-1:0]   paddr,
	input  logic [sbrb_pkg::DATA_W-1:0]   pwdata,
	output logic [sbrb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output sbrb_pkg::cfg_t                cfg
);
	import sbrb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pause_start_ms   <= RST_PAUSE_START;
			cfg_q.first_on_ms      <= RST_FIRST_ON;
			cfg_q.first_off_ms     <= RST_FIRST_OFF;
			cfg_q.pause_mid_ms     <= RST_PAUSE_MID;
			cfg_q.second_on_ms     <= RST_SECOND_ON;
			cfg_q.second_off_ms    <= RST_SECOND_OFF;
			cfg_q.pause_end_ms     <= RST_PAUSE_END;
			cfg_q.long_press_ticks <= RST_LONG_PRESS;
		end else if (wr_en) begin
			case (idx)
				REG_PAUSE_START: cfg_q.pause_start_ms   <= pwdata[DUR_W-1:0];
				REG_FIRST_ON:    cfg_q.first_on_ms      <= pwdata[DUR_W-1:0];
				REG_FIRST_OFF:   cfg_q.first_off_ms     <= pwdata[DUR_W-1:0];
				REG_PAUSE_MID:   cfg_q.pause_mid_ms     <= pwdata[DUR_W-1:0];
				REG_SECOND_ON:   cfg_q.second_on_ms     <= pwdata[DUR_W-1:0];
				REG_SECOND_OFF:  cfg_q.second_off_ms    <= pwdata[DUR_W-1:0];
				REG_PAUSE_END:   cfg_q.pause_end_ms     <= pwdata[DUR_W-1:0];
				REG_LONG_PRESS:  cfg_q.long_press_ticks <= pwdata[PRESS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_PAUSE_START: prdata = DATA_W'(cfg_q.pause_start_ms);
			REG_FIRST_ON:    prdata = DATA_W'(cfg_q.first_on_ms);
			REG_FIRST_OFF:   prdata = DATA_W'(cfg_q.first_off_ms);
			REG_PAUSE_MID:   prdata = DATA_W'(cfg_q.pause_mid_ms);
			REG_SECOND_ON:   prdata = DATA_W'(cfg_q.second_on_ms);
			REG_SECOND_OFF:  prdata = DATA_W'(cfg_q.second_off_ms);
			REG_PAUSE_END:   prdata = DATA_W'(cfg_q.pause_end_ms);
			REG_LONG_PRESS:  prdata = DATA_W'(cfg_q.long_press_ticks);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/sbrb_blink_step.sv
module sbrb_blink_step (
	input  sbrb_pkg::blink_state_t        cur,
	input  sbrb_pkg::cfg_t                cfg,
	input  logic [sbrb_pkg::DELTA_W-1:0]  delta,
	input  logic [sbrb_pkg::CNT_W-1:0]    n1,
	input  logic [sbrb_pkg::CNT_W-1:0]    n2,
	output sbrb_pkg::blink_state_t        nxt
);
	import sbrb_pkg::*;

	logic [SUM_W-1:0] sum;
	timer_t           t_sat;
	logic [DUR_W-1:0] dur;
	logic             reached;
	timer_t           t_left;
	logic             consume;
	phase_t           phase_d;

	// Saturating time advance
	assign sum   = SUM_W'(cur.timer) + SUM_W'(delta);
	assign t_sat = (sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_BITS-1:0];

	// Duration of the current phase
	always_comb begin
		case (cur.phase)
			PH_PAUSE_START: dur = cfg.pause_start_ms;
			PH_FIRST_ON:    dur = cfg.first_on_ms;
			PH_FIRST_OFF:   dur = cfg.first_off_ms;
			PH_PAUSE_MID:   dur = cfg.pause_mid_ms;
			PH_SECOND_ON:   dur = cfg.second_on_ms;
			PH_SECOND_OFF:  dur = cfg.second_off_ms;
			PH_PAUSE_END:   dur = cfg.pause_end_ms;
			default:        dur = '0;
		endcase
	end

	assign reached = t_sat >= TIMER_BITS'(dur);
	assign t_left  = t_sat - TIMER_BITS'(dur);

	// Next phase; consume marks a phase end that uses up its duration
	always_comb begin
		phase_d = cur.phase;
		consume = 1'b0;
		case (cur.phase)
			PH_INIT: begin
				phase_d = PH_PAUSE_START;
			end
			PH_PAUSE_START: begin
				if (n1 == '0) begin
					phase_d = PH_PAUSE_MID;
				end else if (reached) begin
					phase_d = PH_FIRST_ON;
					consume = 1'b1;
				end
			end
			PH_FIRST_ON: begin
				if (reached) begin
					phase_d = PH_FIRST_OFF;
					consume = 1'b1;
				end
			end
			PH_FIRST_OFF: begin
				if (cur.done >= n1) begin
					phase_d = PH_PAUSE_MID;
				end else if (reached) begin
					phase_d = PH_FIRST_ON;
					consume = 1'b1;
				end
			end
			PH_PAUSE_MID: begin
				if (n2 == '0) begin
					phase_d = PH_PAUSE_END;
				end else if (reached) begin
					phase_d = PH_SECOND_ON;
					consume = 1'b1;
				end
			end
			PH_SECOND_ON: begin
				if (reached) begin
					phase_d = PH_SECOND_OFF;
					consume = 1'b1;
				end
			end
			PH_SECOND_OFF: begin
				if (cur.done >= n2) begin
					phase_d = PH_PAUSE_END;
				end else if (reached) begin
					phase_d = PH_SECOND_ON;
					consume = 1'b1;
				end
			end
			PH_PAUSE_END: begin
				if (reached) begin
					phase_d = PH_PAUSE_START;
					consume = 1'b1;
				end
			end
			default: begin
				phase_d = PH_PAUSE_START;
			end
		endcase
	end

	// LEDs, blink count and timer
	always_comb begin
		nxt       = cur;
		nxt.phase = phase_d;
		nxt.timer = consume ? t_left : t_sat;
		case (cur.phase)
			PH_INIT: begin
				nxt.led_first  = 1'b0;
				nxt.led_second = 1'b0;
				nxt.timer      = '0;
			end
			PH_PAUSE_START, PH_PAUSE_MID: begin
				if (consume) begin
					nxt.done = '0;
					if (cur.phase == PH_PAUSE_START) begin
						nxt.led_first = 1'b1;
					end else begin
						nxt.led_second = 1'b1;
					end
				end
			end
			PH_FIRST_ON, PH_SECOND_ON: begin
				if (consume) begin
					if (cur.done != {CNT_W{1'b1}}) begin
						nxt.done = cur.done + CNT_W'(1);
					end
					if (cur.phase == PH_FIRST_ON) begin
						nxt.led_first = 1'b0;
					end else begin
						nxt.led_second = 1'b0;
					end
				end
			end
			PH_FIRST_OFF: begin
				if (consume) begin
					nxt.led_first = 1'b1;
				end
			end
			PH_SECOND_OFF: begin
				if (consume) begin
					nxt.led_second = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/sbrb_tick_unit.sv
module sbrb_tick_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          level,
	input  logic [sbrb_pkg::CNT_W-1:0]    n1,
	input  logic [sbrb_pkg::CNT_W-1:0]    n2,
	input  sbrb_pkg::cfg_t                cfg,
	output sbrb_pkg::result_t             res
);
	import sbrb_pkg::*;

	logic [PRESS_W-1:0] press_q;
	blink_state_t       blink_q;

	logic [PRESS_W-1:0] limit;
	logic [PRESS_W-1:0] press_held;
	logic               held;
	logic               long_hold;
	logic               step_en;
	logic [DELTA_W-1:0] delta;
	logic [CNT_W-1:0]   n1_use;
	logic [CNT_W-1:0]   n2_use;
	blink_state_t       blink_step_nxt;
	blink_state_t       blink_d;
	logic [PRESS_W-1:0] press_d;

	// Press counter, saturating at the long-press limit
	assign limit = (cfg.long_press_ticks == '0) ? PRESS_W'(1) : cfg.long_press_ticks;
	assign held  = !level;

	always_comb begin
		press_held = press_q;
		if (press_q < limit) begin
			press_held = press_q + PRESS_W'(1);
		end
		if (press_held > limit) begin
			press_held = limit;
		end
	end

	assign long_hold = press_held >= limit;
	assign step_en   = held ? long_hold : (press_q == '0);
	assign delta     = held ? DELTA_W'(FAST_STEP_MS) : DELTA_W'(TICK_MS);
	assign n1_use    = held ? CNT_W'(1) : clamp_blinks(n1);
	assign n2_use    = held ? CNT_W'(1) : clamp_blinks(n2);

	sbrb_blink_step u_blink (
		.cur   (blink_q),
		.cfg   (cfg),
		.delta (delta),
		.n1    (n1_use),
		.n2    (n2_use),
		.nxt   (blink_step_nxt)
	);

	// Next state and result for this beat
	always_comb begin
		blink_d = blink_q;
		press_d = '0;
		res     = '0;
		if (held) begin
			press_d = press_held;
		end
		if (step_en) begin
			blink_d = blink_step_nxt;
		end else if (held) begin
			blink_d.led_first  = 1'b0;
			blink_d.led_second = 1'b0;
		end else begin
			// release after a press
			blink_d.led_first   = 1'b1;
			blink_d.led_second  = 1'b1;
			res.restart_request = 1'b1;
			res.erase_request   = press_q >= limit;
		end
		res.led_first  = blink_d.led_first;
		res.led_second = blink_d.led_second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= '0;
			blink_q <= '{phase: PH_INIT, timer: '0, done: '0,
			             led_first: 1'b0, led_second: 1'b0};
		end else if (advance) begin
			press_q <= press_d;
			blink_q <= blink_d;
		end
	end

endmodule

FILE: rtl/core/status_blink_and_reset_button_core.sv
// Status blinker and reset button. Each input beat is one button sample tick
// with the pin level (0 pressed) and the blink counts for the two LEDs; each
// beat yields exactly one result beat with both LED levels and the erase and
// restart pulses. The block takes one beat per clock while out_ready does not
// stall it: a beat is captured in the input register, passes the press counter
// and blink phase logic into the result register, and the press and blink
// state advance as the beat moves into the result register. While a result
// waits for out_ready the input register still takes one more beat; after
// that in_ready stays low until the result drains. Durations are in ms; the
// user must write them over the APB port only while no beat is in flight,
// which the block itself does not enforce.
module status_blink_and_reset_button_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbrb_pkg::ADDR_W-1:0]   paddr,
	input  logic [sbrb_pkg::DATA_W-1:0]   pwdata,
	output logic [sbrb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          button_level,
	input  logic [3:0]                    wifi_blinks,
	input  logic [3:0]                    ble_blinks,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          led_first,
	output logic                          led_second,
	output logic                          erase_request,
	output logic                          restart_request
);
	import sbrb_pkg::*;

	cfg_t             cfg;
	logic             valid_s1;
	logic             level_s1;
	logic [CNT_W-1:0] wifi_s1;
	logic [CNT_W-1:0] ble_s1;
	logic             valid_s2;
	result_t          res_s2;
	result_t          res;
	logic             advance;

	sbrb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: beat moves to the result register when it is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= button_level;
			wifi_s1  <= wifi_blinks;
			ble_s1   <= ble_blinks;
		end
	end

	sbrb_tick_unit u_tick (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.level   (level_s1),
		.n1      (wifi_s1),
		.n2      (ble_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign led_first       = res_s2.led_first;
	assign led_second      = res_s2.led_second;
	assign erase_request   = res_s2.erase_request;
	assign restart_request = res_s2.restart_request;

endmodule

FILE: dv/status_blink_predictor_check.sv
module status_blink_predictor_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [sbrb_pkg::ADDR_W-1:0] paddr,
	input  logic [sbrb_pkg::DATA_W-1:0] pwdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        button_level,
	input  logic [3:0]                  wifi_blinks,
	input  logic [3:0]                  ble_blinks,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        led_first,
	input  logic                        led_second,
	input  logic                        erase_request,
	input  logic                        restart_request,
	output int                          mismatch_count,
	output int                          beats_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbrb_pkg::*;

	// Shadow of the timing registers and of the blinker and press state
	cfg_t               timing;
	phase_t             blink_phase;
	timer_t             blink_timer;
	logic [7:0]         blinks_shown;
	logic [PRESS_W-1:0] held_ticks;
	logic               led1_q;
	logic               led2_q;
	result_t            leds_due[$];

	// Take dur from the timer if it has run that far
	function automatic bit consume_time(input logic [DUR_W-1:0] dur);
		bit hit;
		hit = (blink_timer >= timer_t'(dur));
		if (hit) begin
			blink_timer = blink_timer - timer_t'(dur);
		end
		return hit;
	endfunction

	// One step of the blink sequencer; timer saturates before the phase logic
	function automatic void step_blinker(input int delta, input logic [CNT_W-1:0] n1,
			input logic [CNT_W-1:0] n2);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(blink_timer) + SUM_W'(delta);
		blink_timer = (sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_BITS-1:0];
		case (blink_phase)
		PH_INIT: begin
			blink_phase = PH_PAUSE_START;
			led1_q = 1'b0;
			led2_q = 1'b0;
			blink_timer = '0;
		end
		PH_PAUSE_START: begin
			// no first burst: skip straight to the middle pause
			if (n1 == 0) begin
				blink_phase = PH_PAUSE_MID;
			end else if (consume_time(timing.pause_start_ms)) begin
				blink_phase = PH_FIRST_ON;
				led1_q = 1'b1;
				blinks_shown = '0;
			end
		end
		PH_FIRST_ON: begin
			if (consume_time(timing.first_on_ms)) begin
				blink_phase = PH_FIRST_OFF;
				led1_q = 1'b0;
				if (blinks_shown != 8'hff) begin
					blinks_shown = blinks_shown + 8'd1;
				end
			end
		end
		PH_FIRST_OFF: begin
			if (blinks_shown >= 8'(n1)) begin
				blink_phase = PH_PAUSE_MID;
			end else if (consume_time(timing.first_off_ms)) begin
				blink_phase = PH_FIRST_ON;
				led1_q = 1'b1;
			end
		end
		PH_PAUSE_MID: begin
			// no second burst: skip straight to the end pause
			if (n2 == 0) begin
				blink_phase = PH_PAUSE_END;
			end else if (consume_time(timing.pause_mid_ms)) begin
				blink_phase = PH_SECOND_ON;
				led2_q = 1'b1;
				blinks_shown = '0;
			end
		end
		PH_SECOND_ON: begin
			if (consume_time(timing.second_on_ms)) begin
				blink_phase = PH_SECOND_OFF;
				led2_q = 1'b0;
				if (blinks_shown != 8'hff) begin
					blinks_shown = blinks_shown + 8'd1;
				end
			end
		end
		PH_SECOND_OFF: begin
			if (blinks_shown >= 8'(n2)) begin
				blink_phase = PH_PAUSE_END;
			end else if (consume_time(timing.second_off_ms)) begin
				blink_phase = PH_SECOND_ON;
				led2_q = 1'b1;
			end
		end
		default: begin
			if (consume_time(timing.pause_end_ms)) begin
				blink_phase = PH_PAUSE_START;
			end
		end
		endcase
	endfunction

	// Press counter and release handling for one sample tick
	function automatic result_t take_sample(input logic level, input logic [CNT_W-1:0] n1,
			input logic [CNT_W-1:0] n2);
		result_t            r;
		logic [PRESS_W-1:0] lim;
		// a zero limit behaves as one tick
		lim = (timing.long_press_ticks == 0) ? PRESS_W'(1) : timing.long_press_ticks;
		r = '0;
		if (!level) begin
			if (held_ticks < lim) begin
				held_ticks = held_ticks + PRESS_W'(1);
			end
			if (held_ticks > lim) begin
				held_ticks = lim;
			end
			if (held_ticks >= lim) begin
				step_blinker(FAST_STEP_MS, CNT_W'(1), CNT_W'(1));
			end else begin
				led1_q = 1'b0;
				led2_q = 1'b0;
			end
		end else if (held_ticks != 0) begin
			r.erase_request = (held_ticks >= lim);
			r.restart_request = 1'b1;
			led1_q = 1'b1;
			led2_q = 1'b1;
			held_ticks = '0;
		end else begin
			step_blinker(TICK_MS, n1, n2);
		end
		r.led_first = led1_q;
		r.led_second = led2_q;
		return r;
	endfunction

	// Track register writes, predict on each input beat, compare on each result beat
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			timing = '{RST_PAUSE_START, RST_FIRST_ON, RST_FIRST_OFF, RST_PAUSE_MID,
				RST_SECOND_ON, RST_SECOND_OFF, RST_PAUSE_END, RST_LONG_PRESS};
			blink_phase = PH_INIT;
			blink_timer = '0;
			blinks_shown = '0;
			held_ticks = '0;
			led1_q = 1'b0;
			led2_q = 1'b0;
			leds_due.delete();
			mismatch_count <= 0;
			beats_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_PAUSE_START: timing.pause_start_ms = pwdata[DUR_W-1:0];
				REG_FIRST_ON:    timing.first_on_ms = pwdata[DUR_W-1:0];
				REG_FIRST_OFF:   timing.first_off_ms = pwdata[DUR_W-1:0];
				REG_PAUSE_MID:   timing.pause_mid_ms = pwdata[DUR_W-1:0];
				REG_SECOND_ON:   timing.second_on_ms = pwdata[DUR_W-1:0];
				REG_SECOND_OFF:  timing.second_off_ms = pwdata[DUR_W-1:0];
				REG_PAUSE_END:   timing.pause_end_ms = pwdata[DUR_W-1:0];
				REG_LONG_PRESS:  timing.long_press_ticks = pwdata[PRESS_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				leds_due.push_back(take_sample(button_level, wifi_blinks, ble_blinks));
			end
			if (out_valid && out_ready) begin
				got = {led_first, led_second, erase_request, restart_request};
				if (leds_due.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("%t: result beat with nothing expected: %b%b%b%b",
							$realtime, got.led_first, got.led_second,
							got.erase_request, got.restart_request);
					end
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = leds_due.pop_front();
					if (got.led_first !== want.led_first || got.led_second !== want.led_second ||
							got.erase_request !== want.erase_request ||
							got.restart_request !== want.restart_request) begin
						if (mismatch_count < 10) begin
							$display("%t: mismatch led1 led2 erase restart exp %b%b%b%b got %b%b%b%b",
								$realtime, want.led_first, want.led_second,
								want.erase_request, want.restart_request,
								got.led_first, got.led_second,
								got.erase_request, got.restart_request);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			beats_owed <= leds_due.size();
		end
	end

endmodule

FILE: dv/status_blink_and_reset_button_core_test.sv
module status_blink_and_reset_button_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sbrb_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic              button_level;
	logic [3:0]        wifi_blinks;
	logic [3:0]        ble_blinks;
	logic              out_valid;
	logic              out_ready;
	logic              led_first;
	logic              led_second;
	logic              erase_request;
	logic              restart_request;

	int mismatch_count;
	int beats_owed;
	int quiet_cycles = 0;
	int ticks_sent = 0;
	int press_limit = 30;
	bit steady = 1'b0;

	status_blink_and_reset_button_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_level(button_level),
		.wifi_blinks(wifi_blinks),
		.ble_blinks(ble_blinks),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_first(led_first),
		.led_second(led_second),
		.erase_request(erase_request),
		.restart_request(restart_request)
	);

	status_blink_predictor_check blink_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_level(button_level),
		.wifi_blinks(wifi_blinks),
		.ble_blinks(ble_blinks),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_first(led_first),
		.led_second(led_second),
		.erase_request(erase_request),
		.restart_request(restart_request),
		.mismatch_count(mismatch_count),
		.beats_owed(beats_owed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side backpressure
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 24);
	end

	// Watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One sample tick on the input channel, with random gaps before it
	task automatic send_tick(input logic level, input logic [3:0] n1, input logic [3:0] n2);
		while (!steady && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_level <= level;
		wifi_blinks <= n1;
		ble_blinks <= n2;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		ticks_sent++;
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (beats_owed != 0) begin
			@(posedge clk);
		end
	endtask

	// APB write, junk in the unused upper data bits
	task automatic write_reg(input reg_idx_t idx, input int value, input int width);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= (DATA_W'($urandom()) << width) | DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input int ps, input int fon, input int foff, input int pm,
			input int son, input int soff, input int pe, input int lp);
		write_reg(REG_PAUSE_START, ps, DUR_W);
		write_reg(REG_FIRST_ON, fon, DUR_W);
		write_reg(REG_FIRST_OFF, foff, DUR_W);
		write_reg(REG_PAUSE_MID, pm, DUR_W);
		write_reg(REG_SECOND_ON, son, DUR_W);
		write_reg(REG_SECOND_OFF, soff, DUR_W);
		write_reg(REG_PAUSE_END, pe, DUR_W);
		write_reg(REG_LONG_PRESS, lp, PRESS_W);
		press_limit = (lp == 0) ? 1 : lp;
	endtask

	// Blink counts lean toward zero and small values
	function automatic logic [3:0] pick_count();
		int r;
		r = $urandom_range(9);
		if (r < 2) begin
			return 4'd0;
		end
		if (r < 6) begin
			return 4'($urandom_range(3, 1));
		end
		return 4'($urandom_range(15));
	endfunction

	// Released runs and press/release episodes around the long-press limit, some noise
	task automatic blink_session(input int budget);
		int         stop;
		int         kind;
		int         len;
		logic [3:0] n1;
		logic [3:0] n2;
		stop = ticks_sent + budget;
		while (ticks_sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				len = $urandom_range(40, 1);
				n1 = pick_count();
				n2 = pick_count();
				repeat (len) begin
					if ($urandom_range(15) == 0) begin
						n1 = 4'($urandom_range(15));
						n2 = 4'($urandom_range(15));
					end
					send_tick(1'b1, n1, n2);
				end
			end else if (kind < 90) begin
				case ($urandom_range(2))
				0: len = (press_limit > 1) ? $urandom_range(press_limit - 1, 1) : 1;
				1: len = press_limit;
				default: len = press_limit + $urandom_range(20, 1);
				endcase
				repeat (len) begin
					send_tick(1'b0, 4'($urandom_range(15)), 4'($urandom_range(15)));
				end
				send_tick(1'b1, pick_count(), pick_count());
			end else begin
				repeat ($urandom_range(8, 1)) begin
					send_tick(1'($urandom_range(1)), 4'($urandom_range(15)),
						4'($urandom_range(15)));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		button_level = 1'b1;
		wifi_blinks = '0;
		ble_blinks = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: first step, both zero-count skips, short hold and release
		send_tick(1'b1, 4'd15, 4'd15);
		send_tick(1'b1, 4'd0, 4'd0);
		send_tick(1'b1, 4'd0, 4'd0);
		send_tick(1'b0, 4'd15, 4'd15);
		send_tick(1'b0, 4'd15, 4'd15);
		send_tick(1'b1, 4'b1010, 4'b0101);
		drain();

		// Zero limit acts as one; zero durations let the fast step saturate the timer
		set_timing(0, 0, 0, 0, 0, 0, 0, 0);
		repeat (16) begin
			send_tick(1'b0, 4'd15, 4'd15);
		end
		send_tick(1'b1, 4'd0, 4'd15);
		send_tick(1'b1, 4'd15, 4'd0);
		send_tick(1'b1, 4'd15, 4'd0);
		blink_session(80);
		drain();

		// Largest durations and longest press limit
		set_timing(4095, 4095, 4095, 4095, 4095, 4095, 4095, 255);
		blink_session(250);
		drain();

		// Short durations, quick presses
		set_timing($urandom_range(400), $urandom_range(400), $urandom_range(400),
			$urandom_range(400), $urandom_range(400), $urandom_range(400),
			$urandom_range(400), $urandom_range(8, 1));
		blink_session(200);
		drain();

		// Anything goes
		set_timing($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(255));
		blink_session(120);
		drain();

		// Back to the power-on timing, no gaps and no backpressure
		set_timing(500, 250, 250, 250, 350, 150, 650, 30);
		steady = 1'b1;
		blink_session(150);
		steady = 1'b0;
		drain();

		repeat (5) @(posedge clk);
		if (mismatch_count == 0 && beats_owed == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
